// ===== hdl/lfulru_pkg.sv =====
// Shared types and constants for the LFU cache with LRU tie break.
// Used by lfulru_ctrl, lfulru_dpath and lfu_cache_lru_tiebreak_core.
package lfulru_pkg;

  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int RANK_W     = $clog2(ENTRIES);
  localparam int FILL_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W      = 5;
  localparam int DATA_W     = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
  localparam logic                  FUNC_GET  = 1'b0;
  localparam logic                  FUNC_SET  = 1'b1;

  typedef struct packed {
    logic                     func;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;
    logic signed [DATA_W-1:0] evicted_key;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] ridx;
    logic             update;
  } cmd_t;

endpackage

// ===== hdl/lfulru_ctrl.sv =====
// Controller: accepts an item, steps the entry scan, triggers the update.
// Depends on lfulru_pkg.
module lfulru_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output lfulru_pkg::cmd_t    cmd
);
  import lfulru_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.update = 1'b0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        idx_next = idx + IDX_W'(1);
        if (idx == IDX_W'(ENTRIES - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    cmd.ridx = idx_next;
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/lfulru_dpath.sv =====
// Datapath: entry storage, per-entry scan for match/victim/free slot, update.
// Depends on lfulru_pkg.
module lfulru_dpath (
  input  logic                    clk,
  input  logic                    rst,
  input  lfulru_pkg::cmd_t        cmd,
  input  lfulru_pkg::req_t        req,
  input  logic                    cfg_we,
  input  logic [lfulru_pkg::CAP_W-1:0] cfg_wdata,
  output logic                    done,
  output lfulru_pkg::rsp_t        rsp
);
  import lfulru_pkg::*;

  logic                    valid [ENTRIES];
  logic [DATA_W-1:0]       key_mem [ENTRIES];
  logic [DATA_W-1:0]       val_mem [ENTRIES];
  logic [COUNT_BITS-1:0]   count [ENTRIES];
  logic [RANK_W-1:0]       rank [ENTRIES];
  logic [FILL_W-1:0]       filled;
  logic [CAP_W-1:0]        capacity;

  req_t                    op;

  logic                    hit_found;
  logic [IDX_W-1:0]        hit_idx;
  logic [COUNT_BITS-1:0]   hit_count;
  logic [RANK_W-1:0]       hit_rank;
  logic [DATA_W-1:0]       hit_value;

  logic                    vic_found;
  logic [IDX_W-1:0]        vic_idx;
  logic [COUNT_BITS-1:0]   vic_count;
  logic [RANK_W-1:0]       vic_rank;
  logic [DATA_W-1:0]       vic_key;

  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;

  logic                    s_valid;
  logic [DATA_W-1:0]       s_key;
  logic [DATA_W-1:0]       s_val;
  logic [COUNT_BITS-1:0]   s_count;
  logic [RANK_W-1:0]       s_rank;
  logic                    take_hit;
  logic                    take_vic;
  logic                    take_free;

  logic [CAP_W-1:0]        eff_cap;
  logic                    full;
  logic                    evict;
  logic                    fill;
  logic                    do_write;
  logic [IDX_W-1:0]        slot;
  logic [RANK_W:0]         old_rank;
  logic [COUNT_BITS-1:0]   new_count;
  logic [DATA_W-1:0]       rd_value;

  // scan read at the current index
  assign s_valid = valid[cmd.idx];
  assign s_count = count[cmd.idx];
  assign s_rank  = rank[cmd.idx];

  // prefetch key and value for the next scan index
  always_ff @(posedge clk) begin
    s_key <= key_mem[cmd.ridx];
    s_val <= val_mem[cmd.ridx];
  end

  assign take_hit  = s_valid && (s_key == op.key) && !hit_found;
  assign take_vic  = s_valid && (!vic_found || (s_count < vic_count) ||
                     ((s_count == vic_count) && (s_rank > vic_rank)));
  assign take_free = !s_valid && !free_found;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_W'(ENTRIES)) begin
      eff_cap = CAP_W'(ENTRIES);
    end else begin
      eff_cap = capacity;
    end
    full      = (CAP_W'(filled) >= eff_cap);
    evict     = 1'b0;
    fill      = 1'b0;
    do_write  = 1'b0;
    slot      = hit_idx;
    old_rank  = {1'b0, hit_rank};
    new_count = (hit_count < COUNT_MAX) ? hit_count + COUNT_BITS'(1) : hit_count;
    rd_value  = '1;
    if (hit_found) begin
      do_write = 1'b1;
      rd_value = (op.func == FUNC_SET) ? op.value : hit_value;
    end else if (op.func == FUNC_SET) begin
      rd_value  = op.value;
      new_count = COUNT_BITS'(1);
      if (full && vic_found) begin
        evict    = 1'b1;
        do_write = 1'b1;
        slot     = vic_idx;
        old_rank = {1'b0, vic_rank};
      end else if (free_found) begin
        fill     = 1'b1;
        do_write = 1'b1;
        slot     = free_idx;
        old_rank = (RANK_W + 1)'(ENTRIES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (take_hit) begin
        hit_found <= 1'b1;
      end
      if (take_vic) begin
        vic_found <= 1'b1;
      end
      if (take_free) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (take_hit) begin
        hit_idx   <= cmd.idx;
        hit_count <= s_count;
        hit_rank  <= s_rank;
        hit_value <= s_val;
      end
      if (take_vic) begin
        vic_idx   <= cmd.idx;
        vic_count <= s_count;
        vic_rank  <= s_rank;
        vic_key   <= s_key;
      end
      if (take_free) begin
        free_idx <= cmd.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && do_write) begin
      if (!hit_found) begin
        key_mem[slot] <= op.key;
      end
      if (op.func == FUNC_SET) begin
        val_mem[slot] <= op.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        count[i] <= '0;
        rank[i]  <= '0;
      end
    end else if (cmd.update && do_write) begin
      if (fill) begin
        filled <= filled + FILL_W'(1);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_W'(i) == slot) begin
          valid[i] <= 1'b1;
          count[i] <= new_count;
          rank[i]  <= '0;
        end else if (valid[i] && ({1'b0, rank[i]} < old_rank)) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      rsp.hit         <= hit_found;
      rsp.read_value  <= rd_value;
      rsp.evicted     <= evict;
      rsp.evicted_key <= evict ? vic_key : '0;
    end
  end

endmodule

// ===== hdl/lfu_cache_lru_tiebreak_core.sv =====
// Top level of the LFU key/value cache with LRU tie break.
// Instantiates lfulru_ctrl and lfulru_dpath; depends on lfulru_pkg.
//
//   port group          direction  handshake
//   start / req         in         taken when start && !busy
//   done / rsp          out        one-cycle strobe, no back pressure
//   cfg_we / cfg_wdata  in         capacity written when cfg_we
//
// Each item passes through the accept in idle, a sequential tag/count scan
// over all 16 entries, and then the update state.
// The result appears with done in the cycle after the update; a new item
// may be started in that same cycle. Synchronous reset clears all entries
// and sets capacity to 16. Results cannot be stalled.
module lfu_cache_lru_tiebreak_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  lfulru_pkg::req_t             req,
  input  logic                         cfg_we,
  input  logic [lfulru_pkg::CAP_W-1:0] cfg_wdata,
  output logic                         done,
  output lfulru_pkg::rsp_t             rsp
);
  import lfulru_pkg::*;

  cmd_t cmd;

  lfulru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lfulru_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .rsp       (rsp)
  );

endmodule
